// File: rtl/gpsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpsr_pkg: shared types, constants and microcode for the page strip rotator
// Holds the configuration record, the control word of the sequencer and the
// read-only program that the sequencer steps through.
// ----------------------------------------------------------------------------
package gpsr_pkg;

  localparam int SRC_DEPTH = 256;
  localparam int SRC_AW    = 8;
  localparam int CFG_W     = 7;
  localparam int STEP_W    = 4;

  localparam logic [STEP_W-1:0] STEP_FETCH    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_RD_FIRST = 4'd1;
  localparam logic [STEP_W-1:0] STEP_RD_LAST  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DRAIN    = 4'd9;
  localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd10;

  typedef enum logic [1:0] {
    REG_GLYPH_ROWS  = 2'd0,
    REG_GLYPH_WIDTH = 2'd1,
    REG_TOP_PADDING = 2'd2,
    REG_BOTTOM_UP   = 2'd3
  } reg_idx_t;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    JMP_NEXT    = 2'd0,
    JMP_ON_READ = 2'd1,
    JMP_ON_FREE = 2'd2
  } jmp_t;

  typedef struct packed {
    logic [5:0] glyph_rows;
    logic [6:0] glyph_width;
    logic [5:0] top_padding;
    logic       bottom_up;
  } cfg_t;

  typedef struct packed {
    logic              fetch;
    logic              rd;
    logic [2:0]        rd_row;
    logic              col;
    logic [2:0]        col_bit;
    logic              emit;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic is_read;
    logic out_free;
  } seq_stat_t;

  // Program: fetch, eight row reads (each collecting the previous row's
  // pixel), one drain step for the last pixel, then emit.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] s);
    ctrl_t w;
    w        = '0;
    w.jmp    = JMP_NEXT;
    w.target = STEP_FETCH;
    unique case (s) inside
      STEP_FETCH: begin
        w.fetch  = 1'b1;
        w.jmp    = JMP_ON_READ;
        w.target = STEP_RD_FIRST;
      end
      [STEP_RD_FIRST:STEP_RD_LAST]: begin
        w.rd      = 1'b1;
        w.rd_row  = 3'(s - STEP_RD_FIRST);
        w.col     = (s != STEP_RD_FIRST);
        w.col_bit = 3'(s - STEP_RD_FIRST - 4'd1);
      end
      STEP_DRAIN: begin
        w.col     = 1'b1;
        w.col_bit = 3'(STEP_RD_LAST - STEP_RD_FIRST);
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.jmp    = JMP_ON_FREE;
        w.target = STEP_FETCH;
      end
      default: begin
        w.jmp    = JMP_ON_FREE;
        w.target = STEP_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/gpsr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpsr_req_if: request channel
// Valid/ready channel carrying one write or read request word.
// ----------------------------------------------------------------------------
interface gpsr_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] source_index;
  logic [7:0] source_byte;
  logic [3:0] out_page;
  logic [5:0] out_column;

  modport source (
    output valid, req_type, source_index, source_byte, out_page, out_column,
    input  ready
  );
  modport sink (
    input  valid, req_type, source_index, source_byte, out_page, out_column,
    output ready
  );
endinterface

// File: rtl/gpsr_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpsr_res_if: result channel
// Valid/ready channel carrying one strip byte with the page and column counts.
// ----------------------------------------------------------------------------
interface gpsr_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] strip_byte;
  logic [3:0] page_count;
  logic [6:0] column_count;

  modport source (
    output valid, strip_byte, page_count, column_count,
    input  ready
  );
  modport sink (
    input  valid, strip_byte, page_count, column_count,
    output ready
  );
endinterface

// File: rtl/gpsr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpsr_ram: generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module gpsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: rtl/gpsr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpsr_seq: microcode sequencer
// Step counter over the read-only program, with conditional jumps on request
// acceptance and on a free output register.
// ----------------------------------------------------------------------------
module gpsr_seq (
  input  logic                clk,
  input  logic                rst,
  input  gpsr_pkg::seq_stat_t stat,
  output gpsr_pkg::ctrl_t     ctrl
);
  import gpsr_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  always_comb ctrl = ucode(step);

  always_comb begin
    unique case (ctrl.jmp)
      JMP_NEXT:    step_next = step + 4'd1;
      JMP_ON_READ: step_next = (stat.accept && stat.is_read) ? ctrl.target : step;
      JMP_ON_FREE: step_next = stat.out_free ? ctrl.target : step;
      default:     step_next = STEP_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_FETCH;
    end else begin
      step <= step_next;
    end
  end

  a_read_starts: assert property (@(posedge clk) disable iff (rst)
    stat.accept && stat.is_read |=> step == STEP_RD_FIRST)
    else $error("read request did not start the row reads");

  a_write_stays: assert property (@(posedge clk) disable iff (rst)
    stat.accept && !stat.is_read |=> step == STEP_FETCH)
    else $error("write request left the fetch step");

  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    step == STEP_EMIT && !stat.out_free |=> step == STEP_EMIT)
    else $error("emit step left while output register busy");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= STEP_EMIT)
    else $error("step counter outside program");

endmodule

// File: rtl/gpsr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpsr_dp: strip datapath
// Works out each row's store address, picks the column pixel from the read
// data, packs the strip byte and holds the result word.
// ----------------------------------------------------------------------------
module gpsr_dp #(
  parameter int MAX_ROWS      = 32,
  parameter int MAX_ROW_BYTES = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  gpsr_pkg::cfg_t  cfg,
  input  gpsr_pkg::ctrl_t ctrl,
  input  logic            load,
  input  logic [3:0]      page_in,
  input  logic [5:0]      column_in,
  input  logic [7:0]      rd_data,
  output logic [7:0]      rd_addr,
  output logic            out_free,
  gpsr_res_if.source      res
);
  import gpsr_pkg::*;

  localparam logic [6:0] ROWS_LIM  = 7'(MAX_ROWS);
  localparam logic [7:0] WIDTH_LIM = 8'(MAX_ROW_BYTES * 8);

  logic [3:0]  page_q;
  logic [5:0]  col_q;
  logic [7:0]  strip;
  logic        hit_q;

  logic [6:0]  rows_eff;
  logic [6:0]  width_eff;
  logic [4:0]  row_bytes;
  logic [7:0]  width_pad;
  logic [7:0]  pad_sum;
  logic        col_ok;
  logic [6:0]  pos;
  logic [7:0]  diff;
  logic [6:0]  y;
  logic        hit;
  logic [11:0] prod;
  logic [11:0] addr_full;
  logic        pix;
  logic [2:0]  bit_pos;

  always_comb begin
    rows_eff  = ({1'b0, cfg.glyph_rows} > ROWS_LIM) ? ROWS_LIM : {1'b0, cfg.glyph_rows};
    width_eff = ({1'b0, cfg.glyph_width} > WIDTH_LIM) ? WIDTH_LIM[6:0] : cfg.glyph_width;
    // round width up to 16 pixels, two bytes per 16
    width_pad = {1'b0, width_eff} + 8'd15;
    row_bytes = {width_pad[7:4], 1'b0};
    pad_sum   = {2'b0, cfg.top_padding} + {1'b0, rows_eff} + 8'd7;
    col_ok    = {1'b0, col_q} < width_eff;

    pos       = {page_q, ctrl.rd_row};
    diff      = {1'b0, pos} - {2'b0, cfg.top_padding};
    y         = diff[6:0];
    hit       = col_ok && !diff[7] && (y < rows_eff);
    prod      = 12'(y) * 12'(row_bytes);
    addr_full = prod + 12'(col_q[5:3]);
    rd_addr   = addr_full[7:0];

    pix       = hit_q && rd_data[~col_q[2:0]];
    bit_pos   = cfg.bottom_up ? ctrl.col_bit : ~ctrl.col_bit;
    out_free  = !res.valid || res.ready;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      page_q <= page_in;
      col_q  <= column_in;
    end
    if (ctrl.rd) begin
      hit_q <= hit;
    end
    if (load) begin
      strip <= '0;
    end else if (ctrl.col) begin
      strip[bit_pos] <= pix;
    end
    if (ctrl.emit && out_free) begin
      res.strip_byte   <= strip;
      res.page_count   <= pad_sum[6:3];
      res.column_count <= width_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (ctrl.emit && out_free) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

endmodule

// File: rtl/glyph_row_to_page_strip_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_row_to_page_strip_rotate: glyph row to display page strip rotator
// Loads a 1-bit row-major glyph and reads it back as vertical page bytes.
// ----------------------------------------------------------------------------
// A write request stores one source byte. A read request holds the block
// from the accepting step until its result word is loaded into the output
// register, which waits for that register to be free: the single-port source
// store is read once per pixel row of the strip (eight reads), with one step
// to accept, one to take the last read data and one to load the output
// register. The next request is taken as soon as the result word is loaded,
// even if it has not yet been taken. Writes and reads share the store port,
// so a read in progress holds off further requests. Configuration is written
// through cfg_wr_en, cfg_index and cfg_data; the user must write it only while
// idle; the block does not enforce this. There is no clearing pass after reset.
module glyph_row_to_page_strip_rotate #(
  parameter int MAX_ROWS      = 32,
  parameter int MAX_ROW_BYTES = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  gpsr_req_if.sink              req,
  gpsr_res_if.source            res,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [gpsr_pkg::CFG_W-1:0] cfg_data
);
  import gpsr_pkg::*;

  cfg_t      cfg;
  ctrl_t     ctrl;
  seq_stat_t stat;
  logic      accept;
  logic      ram_en;
  logic      ram_we;
  logic [SRC_AW-1:0] ram_addr;
  logic [SRC_AW-1:0] rd_addr;
  logic [7:0] rd_data;
  logic       out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glyph_rows  <= 6'd8;
      cfg.glyph_width <= 7'd8;
      cfg.top_padding <= 6'd0;
      cfg.bottom_up   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GLYPH_ROWS:  cfg.glyph_rows  <= cfg_data[5:0];
        REG_GLYPH_WIDTH: cfg.glyph_width <= cfg_data[6:0];
        REG_TOP_PADDING: cfg.top_padding <= cfg_data[5:0];
        REG_BOTTOM_UP:   cfg.bottom_up   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign req.ready = ctrl.fetch;
  assign accept    = req.valid && req.ready;

  always_comb begin
    stat.accept   = accept;
    stat.is_read  = (req_kind_t'(req.req_type) == REQ_READ);
    stat.out_free = out_free;
    ram_we        = accept && !stat.is_read;
    ram_en        = ram_we || ctrl.rd;
    ram_addr      = ram_we ? req.source_index : rd_addr;
  end

  gpsr_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  gpsr_ram #(
    .WIDTH (8),
    .DEPTH (SRC_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (req.source_byte),
    .rdata (rd_data)
  );

  gpsr_dp #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ctrl      (ctrl),
    .load      (accept && stat.is_read),
    .page_in   (req.out_page),
    .column_in (req.out_column),
    .rd_data   (rd_data),
    .rd_addr   (rd_addr),
    .out_free  (out_free),
    .res       (res)
  );

endmodule
